/* rtl/core/msq_pkg.sv */
// Shared types, constants and the case table of the marching-squares cell.
`timescale 1ns / 1ps

package msq_pkg;

  // Quotient bits produced by the restoring divider, one per stage.
  localparam int DIV_STEPS = 17;

  // Register stages from the input transaction to the lane coordinate output.
  localparam int LANE_DEPTH = DIV_STEPS + 5;

  // Interpolation factor constants in unsigned Q1.16, 17 bits wide.
  localparam logic [16:0] T_ZERO = 17'd0;
  localparam logic [16:0] T_HALF = 17'd32768;
  localparam logic [16:0] T_ONE  = 17'd65536;

  localparam logic signed [50:0] ROUND_HALF = 51'sd32768;

  typedef enum logic [1:0] {
    EDGE_BOTTOM = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_TOP    = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_t;

  typedef struct packed {
    logic  used;
    edge_t edge_a;
    edge_t edge_b;
  } seg_pair_t;

  typedef struct packed {
    seg_pair_t first;
    seg_pair_t second;
  } cell_segs_t;

  function automatic seg_pair_t mk_pair(input logic used, input edge_t a, input edge_t b);
    seg_pair_t p;
    p.used   = used;
    p.edge_a = a;
    p.edge_b = b;
    return p;
  endfunction

  // Edge pairs for each corner case; saddles are resolved in a fixed way.
  function automatic cell_segs_t cell_segments(input logic [3:0] cs);
    cell_segs_t s;
    s.first  = mk_pair(1'b0, EDGE_BOTTOM, EDGE_BOTTOM);
    s.second = mk_pair(1'b0, EDGE_BOTTOM, EDGE_BOTTOM);
    unique case (cs) inside
      4'd1, 4'd14: s.first = mk_pair(1'b1, EDGE_BOTTOM, EDGE_LEFT);
      4'd2, 4'd13: s.first = mk_pair(1'b1, EDGE_BOTTOM, EDGE_RIGHT);
      4'd3:        s.first = mk_pair(1'b1, EDGE_LEFT, EDGE_RIGHT);
      4'd4, 4'd11: s.first = mk_pair(1'b1, EDGE_TOP, EDGE_LEFT);
      4'd5, 4'd10: s.first = mk_pair(1'b1, EDGE_BOTTOM, EDGE_TOP);
      4'd6: begin
        s.first  = mk_pair(1'b1, EDGE_BOTTOM, EDGE_LEFT);
        s.second = mk_pair(1'b1, EDGE_RIGHT, EDGE_TOP);
      end
      4'd7, 4'd8:  s.first = mk_pair(1'b1, EDGE_RIGHT, EDGE_TOP);
      4'd9: begin
        s.first  = mk_pair(1'b1, EDGE_BOTTOM, EDGE_RIGHT);
        s.second = mk_pair(1'b1, EDGE_LEFT, EDGE_TOP);
      end
      4'd12:       s.first = mk_pair(1'b1, EDGE_RIGHT, EDGE_LEFT);
      default: ;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/msq_edge_lane.sv */
// One edge lane: crossing factor by pipelined division, then linear interpolation.
`timescale 1ns / 1ps

module msq_edge_lane import msq_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] v0,
  input  logic signed [31:0] v1,
  input  logic signed [31:0] iso,
  input  logic signed [31:0] lo,
  input  logic signed [31:0] hi,
  output logic signed [31:0] coord
);

  // Stage one: differences.
  logic signed [32:0] num;
  logic signed [32:0] den;
  logic signed [31:0] lo1;
  logic signed [32:0] span1;

  always_ff @(posedge clk) begin
    if (en) begin
      num   <= {iso[31], iso} - {v0[31], v0};
      den   <= {v1[31], v1} - {v0[31], v0};
      lo1   <= lo;
      span1 <= {hi[31], hi} - {lo[31], lo};
    end
  end

  // Magnitudes and the special factors.
  logic [32:0] an_c;
  logic [32:0] ad_c;
  logic        den_zero;
  logic        opposite;
  logic        spec_c;
  logic [16:0] tspec_c;

  always_comb begin
    an_c     = num[32] ? 33'(-num) : 33'(num);
    ad_c     = den[32] ? 33'(-den) : 33'(den);
    den_zero = (den == 33'sd0);
    opposite = (num == 33'sd0) || (num[32] != den[32]);
    spec_c   = den_zero || opposite || (an_c >= ad_c);
    if (den_zero) begin
      tspec_c = T_HALF;
    end else if (opposite) begin
      tspec_c = T_ZERO;
    end else begin
      tspec_c = T_ONE;
    end
  end

  // Divider stages; entry zero is the load stage, each later one adds a bit.
  logic [33:0]        rem_d   [DIV_STEPS+1];
  logic [16:0]        q_d     [DIV_STEPS+1];
  logic [32:0]        ad_d    [DIV_STEPS+1];
  logic               spec_d  [DIV_STEPS+1];
  logic [16:0]        tspec_d [DIV_STEPS+1];
  logic signed [31:0] lo_d    [DIV_STEPS+1];
  logic signed [32:0] span_d  [DIV_STEPS+1];

  logic [33:0] rem_next [DIV_STEPS];
  logic [16:0] q_next   [DIV_STEPS];

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      logic [33:0] shl;
      logic        fits;
      shl         = {rem_d[j][32:0], 1'b0};
      fits        = (shl >= {1'b0, ad_d[j]});
      rem_next[j] = fits ? (shl - {1'b0, ad_d[j]}) : shl;
      q_next[j]   = {q_d[j][15:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_d[0]   <= {1'b0, an_c};
      q_d[0]     <= '0;
      ad_d[0]    <= ad_c;
      spec_d[0]  <= spec_c;
      tspec_d[0] <= tspec_c;
      lo_d[0]    <= lo1;
      span_d[0]  <= span1;
      for (int j = 1; j <= DIV_STEPS; j++) begin
        rem_d[j]   <= rem_next[j-1];
        q_d[j]     <= q_next[j-1];
        ad_d[j]    <= ad_d[j-1];
        spec_d[j]  <= spec_d[j-1];
        tspec_d[j] <= tspec_d[j-1];
        lo_d[j]    <= lo_d[j-1];
        span_d[j]  <= span_d[j-1];
      end
    end
  end

  // Round the 17-bit quotient to sixteen fraction bits, unsigned Q1.16, half up.
  logic [17:0]        q_round;
  logic [16:0]        t_r;
  logic signed [31:0] lo_t;
  logic signed [32:0] span_t;

  assign q_round = {1'b0, q_d[DIV_STEPS]} + 18'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= spec_d[DIV_STEPS] ? tspec_d[DIV_STEPS] : q_round[17:1];
      lo_t   <= lo_d[DIV_STEPS];
      span_t <= span_d[DIV_STEPS];
    end
  end

  // Product stage.
  logic signed [50:0] prod;
  logic signed [31:0] lo_p;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= $signed({34'd0, t_r}) * 51'(span_t);
      lo_p <= lo_t;
    end
  end

  // Floor of the rounded product over 65536, added to the low end.
  logic signed [50:0] prod_rnd;
  logic signed [50:0] prod_sh;

  assign prod_rnd = prod + ROUND_HALF;
  assign prod_sh  = prod_rnd >>> 16;

  always_ff @(posedge clk) begin
    if (en) begin
      coord <= lo_p + prod_sh[31:0];
    end
  end

endmodule

/* rtl/core/marching_squares_cell.sv */
// A cell's first segment appears once it has passed the lane stages into the output stage.
// Throughput: one cell per cycle while out_ready is high and cells give at most one
// segment each; a cell with two segments holds the output stage until both are sent.
// The pipeline advances as a whole; the output stage sets its pace.
// Synchronous reset clears valid bits, the output sequencer and iso_level (to 0).
`timescale 1ns / 1ps

module marching_squares_cell import msq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value_bl,
  input  logic signed [31:0] value_br,
  input  logic signed [31:0] value_tl,
  input  logic signed [31:0] value_tr,
  input  logic signed [31:0] cell_min_x,
  input  logic signed [31:0] cell_min_y,
  input  logic signed [31:0] cell_max_x,
  input  logic signed [31:0] cell_max_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] seg_start_x,
  output logic signed [31:0] seg_start_y,
  output logic signed [31:0] seg_end_x,
  output logic signed [31:0] seg_end_y,
  output logic [3:0]         case_index,
  output logic               last_segment
);

  // The iso level register; the user must write it only while the block is idle (not enforced here).
  logic signed [31:0] iso_level;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      iso_level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      iso_level <= cfg_data;
    end
  end

  // Global advance. Every stage moves together when the output stage is
  // empty or is retiring its cell this cycle.
  logic en;
  logic accept;

  assign in_ready = en && !rst;
  assign accept   = in_valid && in_ready;

  // Corner case formed at the input transaction, strictly greater is above.
  logic [3:0] cs_in;

  always_comb begin
    cs_in[0] = value_bl > iso_level;
    cs_in[1] = value_br > iso_level;
    cs_in[2] = value_tl > iso_level;
    cs_in[3] = value_tr > iso_level;
  end

  // The edge lanes: bottom, right, top, left.
  logic signed [31:0] coord [4];

  msq_edge_lane u_lane_bottom (
    .clk(clk), .en(en), .v0(value_bl), .v1(value_br), .iso(iso_level),
    .lo(cell_min_x), .hi(cell_max_x), .coord(coord[EDGE_BOTTOM])
  );

  msq_edge_lane u_lane_right (
    .clk(clk), .en(en), .v0(value_br), .v1(value_tr), .iso(iso_level),
    .lo(cell_min_y), .hi(cell_max_y), .coord(coord[EDGE_RIGHT])
  );

  msq_edge_lane u_lane_top (
    .clk(clk), .en(en), .v0(value_tl), .v1(value_tr), .iso(iso_level),
    .lo(cell_min_x), .hi(cell_max_x), .coord(coord[EDGE_TOP])
  );

  msq_edge_lane u_lane_left (
    .clk(clk), .en(en), .v0(value_bl), .v1(value_tl), .iso(iso_level),
    .lo(cell_min_y), .hi(cell_max_y), .coord(coord[EDGE_LEFT])
  );

  // Valid bits, case and box travel beside the lanes, stage for stage.
  logic               vld_d [LANE_DEPTH];
  logic [3:0]         cs_d  [LANE_DEPTH];
  logic signed [31:0] mnx_d [LANE_DEPTH];
  logic signed [31:0] mny_d [LANE_DEPTH];
  logic signed [31:0] mxx_d [LANE_DEPTH];
  logic signed [31:0] mxy_d [LANE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_DEPTH; i++) begin
        vld_d[i] <= 1'b0;
      end
    end else if (en) begin
      vld_d[0] <= accept;
      for (int i = 1; i < LANE_DEPTH; i++) begin
        vld_d[i] <= vld_d[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_d[0]  <= cs_in;
      mnx_d[0] <= cell_min_x;
      mny_d[0] <= cell_min_y;
      mxx_d[0] <= cell_max_x;
      mxy_d[0] <= cell_max_y;
      for (int i = 1; i < LANE_DEPTH; i++) begin
        cs_d[i]  <= cs_d[i-1];
        mnx_d[i] <= mnx_d[i-1];
        mny_d[i] <= mny_d[i-1];
        mxx_d[i] <= mxx_d[i-1];
        mxy_d[i] <= mxy_d[i-1];
      end
    end
  end

  // Crossing points of each edge: the moving coordinate from its lane,
  // the other one fixed by the edge's side of the box.
  localparam int LAST = LANE_DEPTH - 1;

  logic signed [31:0] pt_x [4];
  logic signed [31:0] pt_y [4];

  always_comb begin
    pt_x[EDGE_BOTTOM] = coord[EDGE_BOTTOM];
    pt_y[EDGE_BOTTOM] = mny_d[LAST];
    pt_x[EDGE_RIGHT]  = mxx_d[LAST];
    pt_y[EDGE_RIGHT]  = coord[EDGE_RIGHT];
    pt_x[EDGE_TOP]    = coord[EDGE_TOP];
    pt_y[EDGE_TOP]    = mxy_d[LAST];
    pt_x[EDGE_LEFT]   = mnx_d[LAST];
    pt_y[EDGE_LEFT]   = coord[EDGE_LEFT];
  end

  // Segment assembly. A segment whose ends coincide is dropped here, so
  // the output stage only sees segments that will be sent.
  cell_segs_t         segs;
  logic signed [31:0] a0x, a0y, b0x, b0y, a1x, a1y, b1x, b1y;
  logic               ok0_c;
  logic               ok1_c;

  always_comb begin
    segs  = cell_segments(cs_d[LAST]);
    a0x   = pt_x[segs.first.edge_a];
    a0y   = pt_y[segs.first.edge_a];
    b0x   = pt_x[segs.first.edge_b];
    b0y   = pt_y[segs.first.edge_b];
    a1x   = pt_x[segs.second.edge_a];
    a1y   = pt_y[segs.second.edge_a];
    b1x   = pt_x[segs.second.edge_b];
    b1y   = pt_y[segs.second.edge_b];
    ok0_c = segs.first.used && !(a0x == b0x && a0y == b0y);
    ok1_c = segs.second.used && !(a1x == b1x && a1y == b1y);
  end

  // Output stage: holds both segments of one cell.
  logic               vld_o;
  logic               ok0;
  logic               ok1;
  logic               done0;
  logic [3:0]         cs_o;
  logic signed [31:0] s0_sx, s0_sy, s0_ex, s0_ey;
  logic signed [31:0] s1_sx, s1_sy, s1_ex, s1_ey;

  always_ff @(posedge clk) begin
    if (en) begin
      ok0   <= ok0_c;
      ok1   <= ok1_c;
      cs_o  <= cs_d[LAST];
      s0_sx <= a0x;
      s0_sy <= a0y;
      s0_ex <= b0x;
      s0_ey <= b0y;
      s1_sx <= a1x;
      s1_sy <= a1y;
      s1_ex <= b1x;
      s1_ey <= b1y;
    end
  end

  // The second segment is shown once the first is sent or was dropped.
  logic show1;
  logic pend0;
  logic out_fire;
  logic retire;

  assign pend0        = ok0 && !done0;
  assign show1        = !pend0;
  assign out_valid    = vld_o && (pend0 || ok1);
  assign last_segment = show1 || !ok1;
  assign seg_start_x  = show1 ? s1_sx : s0_sx;
  assign seg_start_y  = show1 ? s1_sy : s0_sy;
  assign seg_end_x    = show1 ? s1_ex : s0_ex;
  assign seg_end_y    = show1 ? s1_ey : s0_ey;
  assign case_index   = cs_o;
  assign out_fire     = out_valid && out_ready;

  // A cell with no segment to send leaves at once.
  assign retire = vld_o && ((!pend0 && !ok1) || (out_fire && last_segment));
  assign en     = !vld_o || retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
      done0 <= 1'b0;
    end else if (en) begin
      vld_o <= vld_d[LAST];
      done0 <= 1'b0;
    end else if (out_fire && !last_segment) begin
      done0 <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // The first segment is only marked sent when a second one follows it.
  a_done_needs_pair : assert property (@(posedge clk) disable iff (rst)
    done0 |-> (ok0 && ok1))
    else $error("first segment marked sent without a second segment");

  // A transaction that is not the last is followed by the last one.
  a_second_follows : assert property (@(posedge clk) disable iff (rst)
    (out_fire && !last_segment) |=> (out_valid && last_segment))
    else $error("second segment of a cell did not follow the first");

  // A stalled output stage keeps its cell.
  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (vld_o && !en) |=> (vld_o && $stable(cs_o) && $stable(s1_sx)))
    else $error("output stage changed while stalled");

  // No transaction right after reset.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
